// ===== sv/error_feedback_unit_rounder_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the error feedback unit rounder
// Shared clocking and reset handling for the checker's properties.
// ----------------------------------------------------------------------------
`ifndef ERROR_FEEDBACK_UNIT_ROUNDER_DEFINES_SVH
`define ERROR_FEEDBACK_UNIT_ROUNDER_DEFINES_SVH

// property checked outside reset
`define EFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define EFR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// efr_pkg
// Register indices and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package efr_pkg;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_STEP    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TOTAL = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch input word, form corrected value
        logic prep;    // take magnitude, clear remainder
        logic step;    // one remainder bit
        logic round;   // form result, update error
        logic finish;  // write output register, update sum
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_div;  // word at the input needs the divide loop
        logic div_last;  // last remainder bit this cycle
        logic out_free;  // output register can take a word
    } t_dp_status;

endpackage

`default_nettype wire

// ===== sv/efr_in_if.sv =====
// ----------------------------------------------------------------------------
// efr_in_if
// Input word channel: value and last-of-run flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface efr_in_if #(
    parameter int VALUE_WIDTH = 48
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] sample_value;
    logic                          is_final;

    modport source (output valid, output sample_value, output is_final, input ready);
    modport sink   (input valid, input sample_value, input is_final, output ready);
endinterface

`default_nettype wire

// ===== sv/efr_out_if.sv =====
// ----------------------------------------------------------------------------
// efr_out_if
// Result word channel: rounded value and last-of-run flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface efr_out_if #(
    parameter int VALUE_WIDTH = 48
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] rounded_value;
    logic                          is_final_out;

    modport source (output valid, output rounded_value, output is_final_out, input ready);
    modport sink   (input valid, input rounded_value, input is_final_out, output ready);
endinterface

`default_nettype wire

// ===== sv/efr_controller.sv =====
// ----------------------------------------------------------------------------
// efr_controller
// Sequencer: accept, divide loop, round, hand off to output register.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_controller (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire efr_pkg::t_dp_status  i_stat,
    output efr_pkg::t_ctrl_cmd        o_cmd
);
    import efr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.need_div ? ST_PREP : ST_ROUND;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = ST_FIN;
            end
            ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/efr_datapath.sv =====
// ----------------------------------------------------------------------------
// efr_datapath
// Config registers, carried error, running sum, bit-serial remainder unit
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_datapath #(
    parameter int VALUE_WIDTH = 48
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // config
    input  wire                                i_cfg_we,
    input  wire  [efr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [VALUE_WIDTH-1:0]             i_cfg_data,
    // input word
    input  wire  signed [VALUE_WIDTH-1:0]      i_sample,
    input  wire                                i_final,
    // output word
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic signed [VALUE_WIDTH-1:0]      o_out_value,
    output logic                               o_out_final,
    // control
    input  wire efr_pkg::t_ctrl_cmd            i_cmd,
    output efr_pkg::t_dp_status                o_stat
);
    import efr_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int SW    = (W + 8 > 64) ? 64 : W + 8;  // running sum
    localparam int CW    = (W < 64) ? W + 1 : 64;      // corrected value
    localparam int CNT_W = $clog2(CW);

    localparam logic [1:0] MODE_DIV  = 2'd0;
    localparam logic [1:0] MODE_PASS = 2'd1;
    localparam logic [1:0] MODE_CORR = 2'd2;

    localparam logic signed [W-1:0]  W_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  W_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [CW-1:0] CW_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CW_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [SW-1:0] SW_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SW_MIN = {1'b1, {(SW-1){1'b0}}};

    // config
    logic        [W-2:0]     r_unit;
    logic signed [W-1:0]     r_target;
    // state
    logic signed [W-1:0]     r_err;
    logic signed [SW-1:0]    r_sum;
    // work registers
    logic signed [CW-1:0]    r_val;
    logic                    r_final;
    logic [1:0]              r_mode;
    logic [CW-1:0]           r_shift;
    logic [W-2:0]            r_rem;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [W-1:0]     r_res;
    // output register
    logic                    r_out_valid;
    logic signed [W-1:0]     r_out_value;
    logic                    r_out_final;

    // --- load: corrected value and mode
    logic signed [W:0]       corr_wide;
    logic [W-CW+1:0]         corr_hi;
    logic signed [CW-1:0]    corr_sat;
    logic [1:0]              mode_in;

    assign corr_wide = (W+1)'(i_sample) + (W+1)'(r_err);
    assign corr_hi   = corr_wide[W:CW-1];
    assign corr_sat  = ((&corr_hi) || !(|corr_hi)) ? corr_wide[CW-1:0]
                     : (corr_wide[W] ? CW_MIN : CW_MAX);

    always_comb begin
        if (i_final && (r_target != '0)) begin
            mode_in = MODE_CORR;
        end else if (r_unit == '0) begin
            mode_in = MODE_PASS;
        end else begin
            mode_in = MODE_DIV;
        end
    end

    // --- one restoring remainder step
    logic [W-1:0]            rem_trial;
    logic [W-1:0]            rem_next;

    assign rem_trial = {r_rem, r_shift[CW-1]};
    assign rem_next  = (rem_trial >= {1'b0, r_unit}) ? rem_trial - {1'b0, r_unit}
                                                     : rem_trial;

    // --- rounding: rounded = corrected - signed remainder
    logic                    val_neg;
    logic signed [CW-1:0]    rem_ext;
    logic signed [CW-1:0]    rounded;
    logic [CW-W:0]           rnd_hi;
    logic signed [W-1:0]     rnd_sat;
    logic signed [SW:0]      diff;
    logic [SW-W+1:0]         diff_hi;
    logic signed [W-1:0]     diff_sat;
    logic signed [W-1:0]     res_next;

    assign val_neg  = r_val[CW-1];
    assign rem_ext  = $signed(CW'(r_rem));
    assign rounded  = val_neg ? r_val + rem_ext : r_val - rem_ext;
    assign rnd_hi   = rounded[CW-1:W-1];
    assign rnd_sat  = ((&rnd_hi) || !(|rnd_hi)) ? rounded[W-1:0]
                    : (rounded[CW-1] ? W_MIN : W_MAX);

    assign diff     = (SW+1)'(r_target) - (SW+1)'(r_sum);
    assign diff_hi  = diff[SW:W-1];
    assign diff_sat = ((&diff_hi) || !(|diff_hi)) ? diff[W-1:0]
                    : (diff[SW] ? W_MIN : W_MAX);

    always_comb begin
        case (r_mode)
            MODE_PASS: res_next = r_val[W-1:0];
            MODE_CORR: res_next = diff_sat;
            default:   res_next = rnd_sat;
        endcase
    end

    // --- running sum, saturating
    logic signed [SW:0]      sum_wide;
    logic [1:0]              sum_hi;
    logic signed [SW-1:0]    sum_sat;

    assign sum_wide = (SW+1)'(r_sum) + (SW+1)'(r_res);
    assign sum_hi   = sum_wide[SW:SW-1];
    assign sum_sat  = ((&sum_hi) || !(|sum_hi)) ? sum_wide[SW-1:0]
                    : (sum_wide[SW] ? SW_MIN : SW_MAX);

    // --- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit      <= '0;
            r_target    <= '0;
            r_err       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_UNIT_STEP:    r_unit   <= i_cfg_data[W-2:0];
                    REG_TARGET_TOTAL: r_target <= i_cfg_data;
                endcase
            end

            if (i_cmd.round && (r_mode == MODE_DIV)) begin
                // new error = rounded - corrected = -(signed remainder)
                r_err <= val_neg ? $signed({1'b0, r_rem}) : -$signed({1'b0, r_rem});
            end

            if (i_cmd.finish) begin
                if (r_final) begin
                    r_err <= '0;
                    r_sum <= '0;
                end else begin
                    r_sum <= sum_sat;
                end
            end

            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // --- payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val   <= (mode_in == MODE_PASS) ? CW'(i_sample) : corr_sat;
            r_final <= i_final;
            r_mode  <= mode_in;
        end
        if (i_cmd.prep) begin
            r_shift <= val_neg ? -r_val : r_val;
            r_rem   <= '0;
            r_cnt   <= '0;
        end
        if (i_cmd.step) begin
            r_shift <= r_shift << 1;
            r_rem   <= rem_next[W-2:0];
            r_cnt   <= r_cnt + 1'b1;
        end
        if (i_cmd.round) begin
            r_res <= res_next;
        end
        if (i_cmd.finish) begin
            r_out_value <= r_res;
            r_out_final <= r_final;
        end
    end

    assign o_stat.need_div = (mode_in == MODE_DIV);
    assign o_stat.div_last = (r_cnt == CNT_W'(CW - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_final = r_out_final;

endmodule

`default_nettype wire

// ===== sv/error_feedback_unit_rounder.sv =====
// ----------------------------------------------------------------------------
// error_feedback_unit_rounder
// Error-feedback rounding of a fixed-point word stream to a multiple of a
// unit, with the last word of a run corrected to hit a target total.
// ----------------------------------------------------------------------------
// Each input word (signed, FRAC_BITS-agnostic raw code) is added to the
// carried error, then truncated toward zero to a whole multiple of
// unit_step; the difference becomes the new carried error and the emitted
// word is added to a saturating running sum. A zero unit passes words
// through. On the last word of a run with a nonzero target_total the result
// is target_total minus the running sum. Error and sum clear after the last
// word. One result word per input word, results saturate to VALUE_WIDTH.
// One word at a time. A rounded word goes through the prep step, the
// bit-serial remainder loop over the CW = VALUE_WIDTH + 1 bits (64 at full
// width) of the corrected value, one quotient bit per cycle, the round step
// and the finish step, which waits for a free output register. Pass-through
// and target-corrected words skip the prep step and the loop. The output
// register holds a finished word while the next one is accepted and worked
// on. Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module error_feedback_unit_rounder #(
    parameter int VALUE_WIDTH = 48
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    efr_in_if.sink                          i_in_word,
    efr_out_if.source                       o_out_word,
    input  wire                             i_cfg_we,
    input  wire [efr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [VALUE_WIDTH-1:0]           i_cfg_data
);
    import efr_pkg::*;

    t_ctrl_cmd   ctrl_cmd;   // sequencer commands
    t_dp_status  dp_stat;    // datapath status back to the sequencer
    logic        in_ready;

    // sequencer: ready only when idle; one word in flight
    efr_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_word.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (ctrl_cmd)
    );

    assign i_in_word.ready = in_ready;

    // datapath: state, remainder unit, output register
    efr_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_in_word.sample_value),
        .i_final     (i_in_word.is_final),
        .o_out_valid (o_out_word.valid),
        .i_out_ready (o_out_word.ready),
        .o_out_value (o_out_word.rounded_value),
        .o_out_final (o_out_word.is_final_out),
        .i_cmd       (ctrl_cmd),
        .o_stat      (dp_stat)
    );

endmodule

`default_nettype wire

// ===== sv/efr_checker.sv =====
// ----------------------------------------------------------------------------
// efr_checker
// Port-level checks on the rounder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "error_feedback_unit_rounder_defines.svh"

module efr_checker #(
    parameter int VALUE_WIDTH = 48
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_in_valid,
    input wire                   i_in_ready,
    input wire                   i_out_valid,
    input wire                   i_out_ready,
    input wire [VALUE_WIDTH-1:0] i_out_value,
    input wire                   i_out_final
);

    // out of reset: nothing pending, ready for a word
    `EFR_ASSERT_RST(a_reset_state, !i_rst_n |=> !i_out_valid && i_in_ready, "bad state after reset")

    // one word in flight: ready drops once a word is taken
    `EFR_ASSERT(a_one_in_flight, i_in_valid && i_in_ready |=> !i_in_ready, "ready held after accept")

    // a new result appears only as the sequencer returns to idle
    `EFR_ASSERT(a_result_at_idle, $rose(i_out_valid) |-> i_in_ready, "result without idle")

    // stalled result word holds
    `EFR_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value) && $stable(i_out_final), "stalled result changed")

endmodule

bind error_feedback_unit_rounder efr_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_efr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_word.valid),
    .i_in_ready  (i_in_word.ready),
    .i_out_valid (o_out_word.valid),
    .i_out_ready (o_out_word.ready),
    .i_out_value (o_out_word.rounded_value),
    .i_out_final (o_out_word.is_final_out)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: error feedback unit rounder testbench
// Streams signed words through the rounder under a range of unit and target
// settings and checks every result word against an in-bench prediction of
// the rounding, the carried error, the running sum and the final correction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import efr_pkg::*;

    localparam int VW          = 48;
    localparam int SUM_W       = 56;   // running sum is VW + 8 bits wide
    localparam int HOLD_AT     = 40;   // output word count that starts the long stall
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LO    = 800;  // word window with no idling on either side
    localparam int QUIET_HI    = 1000;
    localparam int PRINT_CAP   = 100;  // keep the log short if the block is badly off
    localparam int TAIL_CYCLES = 60;

    localparam logic signed [VW-1:0] MAXV = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] MINV = {1'b1, {(VW-1){1'b0}}};

    typedef struct {
        logic signed [VW-1:0] value;
        logic                 last;
    } t_word;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [VW-1:0]   i_cfg_data;

    efr_in_if  #(.VALUE_WIDTH(VW)) in_bus ();
    efr_out_if #(.VALUE_WIDTH(VW)) out_bus ();

    error_feedback_unit_rounder #(
        .VALUE_WIDTH(VW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (in_bus),
        .o_out_word (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // words waiting to be offered, and results owed by the block
    t_word pending_samples[$];
    t_word expected_results[$];

    // predicted block state and register copies
    longint fb_error;
    longint run_sum;
    longint cfg_unit;
    longint cfg_target;

    int unsigned words_in      = 0;
    int unsigned words_out     = 0;
    int unsigned err_count     = 0;
    int unsigned settings_used = 0;
    int          hold_left;
    logic        hold_done;
    logic        quiet_in;
    logic        quiet_out;
    t_word       taken_word;
    t_word       next_word;
    t_word       owed_word;

    assign quiet_in  = (words_in  >= QUIET_LO) && (words_in  < QUIET_HI);
    assign quiet_out = (words_out >= QUIET_LO) && (words_out < QUIET_HI);

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic longint clamp_to(longint x, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (x > hi)
            return hi;
        if (x < -hi - 1)
            return -hi - 1;
        return x;
    endfunction

    // One word in, one word out. The divide truncates toward zero; the
    // carried error comes from the unclamped rounded value, the sum from the
    // clamped one. A last word with a nonzero target skips rounding and
    // returns whatever brings the run to the target.
    function automatic t_word round_with_feedback(t_word s);
        t_word  r;
        longint corrected;
        longint rounded;
        longint outv;
        if (!s.last || cfg_target == 0) begin
            if (cfg_unit != 0) begin
                corrected = s.value + fb_error;
                rounded   = (corrected / cfg_unit) * cfg_unit;
                fb_error  = rounded - corrected;
                outv      = clamp_to(rounded, VW);
            end else begin
                outv = s.value;
            end
            run_sum = clamp_to(run_sum + outv, SUM_W);
        end else begin
            outv = clamp_to(cfg_target - run_sum, VW);
        end
        if (s.last) begin
            fb_error = 0;
            run_sum  = 0;
        end
        r.value = outv[VW-1:0];
        r.last  = s.last;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------

    // log is capped so that a badly broken block cannot flood it; every
    // mismatch still counts
    task automatic flag_mismatch(string what);
        if (err_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Input driver: offers queued words, idles now and then between words.
    // A word that is offered stays put until taken. The prediction runs on
    // the edge the word is taken, so state and registers line up with it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid        <= 1'b0;
            in_bus.sample_value <= '0;
            in_bus.is_final     <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                taken_word.value = in_bus.sample_value;
                taken_word.last  = in_bus.is_final;
                expected_results.push_back(round_with_feedback(taken_word));
                words_in <= words_in + 1;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_samples.size() != 0 &&
                    (quiet_in || $urandom_range(0, 99) >= 8)) begin
                    next_word = pending_samples.pop_front();
                    in_bus.valid        <= 1'b1;
                    in_bus.sample_value <= next_word.value;
                    in_bus.is_final     <= next_word.last;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long output stall: once HOLD_AT words have come out, hold ready low while
    // a HOLD_CYCLES countdown runs, so the output register and the word in flight
    // back up and the input side has to stall while the driver keeps offering.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_out == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: checks each word taken against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                words_out <= words_out + 1;
                if (expected_results.size() == 0) begin
                    flag_mismatch($sformatf("word %0d arrived with nothing owed",
                                            words_out));
                end else begin
                    owed_word = expected_results.pop_front();
                    if (out_bus.rounded_value !== owed_word.value)
                        flag_mismatch($sformatf("word %0d rounded_value %0d, expected %0d",
                                                words_out, out_bus.rounded_value,
                                                owed_word.value));
                    if (out_bus.is_final_out !== owed_word.last)
                        flag_mismatch($sformatf("word %0d is_final_out %b, expected %b",
                                                words_out, out_bus.is_final_out,
                                                owed_word.last));
                end
            end
            if (hold_left != 0 || (!hold_done && words_out == HOLD_AT))
                out_bus.ready <= 1'b0;
            else
                out_bus.ready <= quiet_out || ($urandom_range(0, 99) >= 8);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void add_word(logic signed [VW-1:0] v, logic last);
        t_word w;
        w.value = v;
        w.last  = last;
        pending_samples.push_back(w);
    endfunction

    function automatic logic [VW-1:0] rand_bits();
        return VW'({$urandom, $urandom});
    endfunction

    // mostly full-range words, with a fair share of extremes and small values
    function automatic logic signed [VW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return MAXV;
            1:       return MINV;
            2:       return VW'(longint'($urandom_range(0, 2097152)) - 1048576);
            3:       return VW'(longint'($urandom_range(0, 4)) - 2);
            default: return rand_bits();
        endcase
    endfunction

    // runs of up to 16 words closed by a last word; now and then a stray
    // last flag cuts a run short
    task automatic add_runs(int count);
        int left;
        int run_len;
        left = count;
        while (left > 0) begin
            run_len = $urandom_range(1, 16);
            if (run_len > left)
                run_len = left;
            for (int k = 0; k < run_len; k++)
                add_word(pick_sample(), k == run_len - 1 || $urandom_range(0, 19) == 0);
            left -= run_len;
        end
    endtask

    // every word offered, taken and answered
    task automatic drain();
        @(negedge i_clk);
        while (pending_samples.size() != 0 || expected_results.size() != 0 || in_bus.valid)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VW-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == REG_UNIT_STEP)
            cfg_unit = longint'({1'b0, data[VW-2:0]});   // top bit is not stored
        else if (idx == REG_TARGET_TOTAL)
            cfg_target = longint'(signed'(data));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // registers change only with the block idle; words pushed after this
    // go in on a falling edge, clear of the driver
    task automatic apply_setting(logic [VW-1:0] unit_data, logic [VW-1:0] target_data);
        drain();
        write_reg(REG_UNIT_STEP, unit_data);
        write_reg(REG_TARGET_TOTAL, target_data);
        settings_used++;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        in_bus.valid        = 1'b0;
        in_bus.sample_value = '0;
        in_bus.is_final     = 1'b0;
        out_bus.ready       = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        fb_error   = 0;
        run_sum    = 0;
        cfg_unit   = 0;
        cfg_target = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pass-through: extremes, zero, a last word with no target
        apply_setting('0, '0);
        add_word(MAXV, 1'b0);
        add_word(MINV, 1'b0);
        add_word(0, 1'b0);
        add_word(-1, 1'b0);
        add_word(1, 1'b1);

        // unit of 1.0: plain rounding with the error carried across words
        apply_setting(48'd65536, '0);
        add_word(100000, 1'b0);
        add_word(-100000, 1'b0);
        add_word(196609, 1'b0);
        add_word(-1, 1'b0);
        add_word(70000, 1'b1);

        // unit of 3: max then min drives the corrected value past the
        // negative end, so the rounded word clamps; last word corrected
        apply_setting(48'd3, 48'd1000);
        add_word(MAXV, 1'b0);
        add_word(MINV, 1'b0);
        add_word(MINV, 1'b0);
        add_word(5, 1'b1);

        // largest unit, written with the ignored top bit set; most negative
        // target, where target minus sum clamps
        apply_setting('1, MINV);
        add_word(MAXV, 1'b0);
        add_word(MAXV, 1'b0);
        add_word(-5, 1'b0);
        add_word(MINV, 1'b0);
        add_word(0, 1'b1);

        // smallest unit, largest target
        apply_setting(48'd1, MAXV);
        add_word(12345, 1'b0);
        add_word(-7, 1'b1);

        // random pass-through runs with a target; the long output stall
        // lands here, where words are quick enough to back the block up
        apply_setting('0, rand_bits());
        add_runs(100);

        // running sum saturation both ways, then the correction clamps
        apply_setting('0, MAXV);
        for (int k = 0; k < 259; k++)
            add_word(MAXV, 1'b0);
        add_word(0, 1'b1);
        for (int k = 0; k < 259; k++)
            add_word(MINV, 1'b0);
        add_word(0, 1'b1);

        // random rounding runs over a spread of settings
        apply_setting(48'd65536, '0);
        add_runs(110);
        apply_setting(48'd1, MAXV);
        add_runs(110);
        apply_setting(MAXV, MINV);
        add_runs(110);
        apply_setting(48'd3, rand_bits());
        add_runs(110);
        apply_setting(VW'($urandom_range(2, 1 << 20)), rand_bits());
        add_runs(110);
        apply_setting(rand_bits(), $urandom_range(0, 1) ? rand_bits() : '0);
        add_runs(110);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            flag_mismatch($sformatf("%0d words never came out", expected_results.size()));

        $display("run covered %0d words in, %0d out, over %0d register settings",
                 words_in, words_out, settings_used);
        $display("incl. pass-through, rounding, target correction, saturation, %0d-cycle stall",
                 HOLD_CYCLES);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard stop, many times the slowest correct run
    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/efr_pkg.sv
sv/efr_in_if.sv
sv/efr_out_if.sv
sv/efr_controller.sv
sv/efr_datapath.sv
sv/error_feedback_unit_rounder.sv
sv/efr_checker.sv
tb/tb.sv
